/* hdl/satellite_message_deframer_unit_defines.svh */
// Assertion macros for the satellite message deframer.
// Included by RTL files that carry concurrent checks; no other dependencies.
`ifndef SATELLITE_MESSAGE_DEFRAMER_UNIT_DEFINES_SVH
`define SATELLITE_MESSAGE_DEFRAMER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define SMD_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("deframer check failed");
`define SMD_ASSERT_RST(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("deframer reset check failed");
`else
`define SMD_ASSERT(label, prop)
`define SMD_ASSERT_RST(label, prop)
`endif
`endif

/* hdl/smd_pkg.sv */
// Shared types and constants for the satellite message deframer.
// Used by smd_step and satellite_message_deframer_unit; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package smd_pkg;

  localparam logic [7:0] CH_START = 8'h24;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_X     = 8'h58;
  localparam logic [7:0] CH_F     = 8'h46;
  localparam logic [7:0] CH_K     = 8'h4B;

  localparam logic [4:0] POS_FIRST    = 5'd1;
  localparam logic [4:0] POS_SECOND   = 5'd2;
  localparam logic [4:0] POS_FIELDS   = 5'd5;
  localparam logic [4:0] POS_ADDR_LO  = 5'd11;
  localparam logic [4:0] POS_ADDR_HI  = 5'd13;
  localparam logic [4:0] POS_LEN_HIGH = 5'd16;
  localparam logic [4:0] POS_LEN_LOW  = 5'd17;
  localparam logic [4:0] POS_PAYLOAD  = 5'd18;
  localparam logic [1:0] TRAILER_LEN  = 2'd2;

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_HEAD,
    PH_FIELDS,
    PH_PAYLOAD,
    PH_TRAILER
  } phase_t;

  typedef enum logic [1:0] {
    KIND_DATA,
    KIND_ACK,
    KIND_REJECT,
    KIND_EMPTY
  } kind_t;

  typedef struct packed {
    phase_t      phase;
    logic [4:0]  byte_pos;
    logic        saw_f;
    logic [23:0] sender_reg;
    logic [7:0]  len_high;
    logic [12:0] msg_len;
    logic [12:0] msg_count;
    logic [1:0]  trailer_left;
  } state_t;

  typedef struct packed {
    logic        has;
    kind_t       kind;
    logic [7:0]  data_byte;
    logic [23:0] sender_addr;
    logic [12:0] payload_len;
    logic        last;
  } result_t;

endpackage
`default_nettype wire

/* hdl/smd_step.sv */
// Next-state and result logic of the deframer for one received byte.
// Depends on smd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module smd_step (
  input  var smd_pkg::state_t  st,
  input  wire logic [7:0]      in_byte,
  output var smd_pkg::state_t  st_next,
  output var smd_pkg::result_t res
);

  logic [15:0] len_bits;
  logic [12:0] len_bytes;
  logic [12:0] count_inc;
  logic [4:0]  pos_inc;
  logic [1:0]  trailer_dec;

  assign len_bits    = {st.len_high, in_byte};
  assign len_bytes   = len_bits[15:3];
  assign count_inc   = st.msg_count + 13'd1;
  assign pos_inc     = st.byte_pos + 5'd1;
  assign trailer_dec = st.trailer_left - 2'd1;

  always_comb begin
    st_next         = st;
    res.has         = 1'b0;
    res.kind        = smd_pkg::KIND_DATA;
    res.data_byte   = 8'd0;
    res.sender_addr = 24'd0;
    res.payload_len = 13'd0;
    res.last        = 1'b0;
    unique case (st.phase)
      smd_pkg::PH_HUNT: begin
        if (in_byte == smd_pkg::CH_START) begin
          st_next.phase    = smd_pkg::PH_HEAD;
          st_next.byte_pos = smd_pkg::POS_FIRST;
          st_next.saw_f    = 1'b0;
        end
      end
      smd_pkg::PH_HEAD: begin
        priority if (st.byte_pos == smd_pkg::POS_FIRST) begin
          if (in_byte == smd_pkg::CH_F || in_byte == smd_pkg::CH_T) begin
            st_next.saw_f    = (in_byte == smd_pkg::CH_F);
            st_next.byte_pos = smd_pkg::POS_SECOND;
          end else begin
            st_next.phase    = smd_pkg::PH_HUNT;
            st_next.byte_pos = 5'd0;
            st_next.saw_f    = 1'b0;
            res.has          = 1'b1;
            res.kind         = smd_pkg::KIND_REJECT;
            res.last         = 1'b1;
          end
        end else if (st.byte_pos == smd_pkg::POS_SECOND && st.saw_f) begin
          st_next.phase    = smd_pkg::PH_HUNT;
          st_next.byte_pos = 5'd0;
          st_next.saw_f    = 1'b0;
          res.has          = 1'b1;
          res.kind         = (in_byte == smd_pkg::CH_K) ? smd_pkg::KIND_ACK
                                                        : smd_pkg::KIND_REJECT;
          res.last         = 1'b1;
        end else if (in_byte != smd_pkg::CH_X) begin
          st_next.phase    = smd_pkg::PH_HUNT;
          st_next.byte_pos = 5'd0;
          st_next.saw_f    = 1'b0;
          res.has          = 1'b1;
          res.kind         = smd_pkg::KIND_REJECT;
          res.last         = 1'b1;
        end else begin
          st_next.byte_pos = pos_inc;
          if (pos_inc >= smd_pkg::POS_FIELDS) begin
            st_next.phase = smd_pkg::PH_FIELDS;
          end
        end
      end
      smd_pkg::PH_FIELDS: begin
        if (st.byte_pos >= smd_pkg::POS_ADDR_LO && st.byte_pos <= smd_pkg::POS_ADDR_HI) begin
          st_next.sender_reg = {st.sender_reg[15:0], in_byte};
        end else if (st.byte_pos == smd_pkg::POS_LEN_HIGH) begin
          st_next.len_high = in_byte;
        end
        if (st.byte_pos == smd_pkg::POS_LEN_LOW) begin
          st_next.msg_len   = len_bytes;
          st_next.msg_count = 13'd0;
          st_next.byte_pos  = smd_pkg::POS_PAYLOAD;
          if (len_bytes == 13'd0) begin
            st_next.phase        = smd_pkg::PH_TRAILER;
            st_next.trailer_left = smd_pkg::TRAILER_LEN;
            res.has              = 1'b1;
            res.kind             = smd_pkg::KIND_EMPTY;
            res.sender_addr      = st.sender_reg;
            res.last             = 1'b1;
          end else begin
            st_next.phase = smd_pkg::PH_PAYLOAD;
          end
        end else begin
          st_next.byte_pos = pos_inc;
        end
      end
      smd_pkg::PH_PAYLOAD: begin
        st_next.msg_count = count_inc;
        res.has           = 1'b1;
        res.kind          = smd_pkg::KIND_DATA;
        res.data_byte     = in_byte;
        res.sender_addr   = st.sender_reg;
        res.payload_len   = st.msg_len;
        res.last          = (count_inc >= st.msg_len);
        if (count_inc >= st.msg_len) begin
          st_next.phase        = smd_pkg::PH_TRAILER;
          st_next.trailer_left = smd_pkg::TRAILER_LEN;
        end
      end
      smd_pkg::PH_TRAILER: begin
        st_next.trailer_left = trailer_dec;
        if (trailer_dec == 2'd0) begin
          st_next.phase    = smd_pkg::PH_HUNT;
          st_next.byte_pos = 5'd0;
          st_next.saw_f    = 1'b0;
        end
      end
      default: begin
        st_next.phase    = smd_pkg::PH_HUNT;
        st_next.byte_pos = 5'd0;
        st_next.saw_f    = 1'b0;
      end
    endcase
  end

endmodule
`default_nettype wire

/* hdl/satellite_message_deframer_unit.sv */
// Deframer top level: input register, frame state, result register.
// A byte waits in the input register; its result is registered when the state advances.
// Throughput: one byte per cycle; a byte stalls only behind a result that is not taken.
// Reset (rst, synchronous): hunt for the start byte, both registers empty.
// Depends on smd_pkg, smd_step and satellite_message_deframer_unit_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "satellite_message_deframer_unit_defines.svh"
module satellite_message_deframer_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output wire logic        in_ready,
  input  wire logic [7:0]  in_byte,
  output wire logic        out_valid,
  input  wire logic        out_ready,
  output wire logic [1:0]  kind,
  output wire logic [7:0]  data_byte,
  output wire logic [23:0] sender_addr,
  output wire logic [12:0] payload_len,
  output wire logic        last
);

  logic             in_full;
  logic [7:0]       in_reg;
  smd_pkg::state_t  st;
  smd_pkg::state_t  st_next;
  smd_pkg::result_t res;
  smd_pkg::result_t out_reg;
  logic             out_full;
  logic             advance;

  smd_step u_step (
    .st      (st),
    .in_byte (in_reg),
    .st_next (st_next),
    .res     (res)
  );

  assign advance  = in_full && (!out_full || out_ready || !res.has);
  assign in_ready = !in_full || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full          <= 1'b0;
      out_full         <= 1'b0;
      st.phase         <= smd_pkg::PH_HUNT;
      st.byte_pos      <= 5'd0;
      st.saw_f         <= 1'b0;
      st.sender_reg    <= 24'd0;
      st.len_high      <= 8'd0;
      st.msg_len       <= 13'd0;
      st.msg_count     <= 13'd0;
      st.trailer_left  <= 2'd0;
    end else begin
      if (in_ready) begin
        in_full <= in_valid;
      end
      if (advance) begin
        st <= st_next;
      end
      if (advance && res.has) begin
        out_full <= 1'b1;
      end else if (out_ready) begin
        out_full <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_reg <= in_byte;
    end
    if (advance && res.has) begin
      out_reg <= res;
    end
  end

  assign out_valid   = out_full;
  assign kind        = out_reg.kind;
  assign data_byte   = out_reg.data_byte;
  assign sender_addr = out_reg.sender_addr;
  assign payload_len = out_reg.payload_len;
  assign last        = out_reg.last;

  `SMD_ASSERT(a_hold_input, in_full && !advance |=> in_full && $stable(in_reg))
  `SMD_ASSERT(a_payload_len, st.phase == smd_pkg::PH_PAYLOAD |-> st.msg_len != 13'd0)
  `SMD_ASSERT(a_trailer_left, st.phase == smd_pkg::PH_TRAILER |-> st.trailer_left != 2'd0)
  `SMD_ASSERT(a_status_last, out_valid && kind != smd_pkg::KIND_DATA |-> last)
  `SMD_ASSERT_RST(a_reset_empty, rst |=> !in_full && !out_valid)

endmodule
`default_nettype wire

/* dv/tb_satellite_message_deframer_unit.sv */
// Self-checking testbench for satellite_message_deframer_unit: drives serial bytes,
// predicts every deframer result in a scoreboard class and checks each one in order.
// Depends on smd_pkg and the deframer RTL only.
`timescale 1ns / 1ps
module tb_satellite_message_deframer_unit;

  localparam int unsigned CYCLE_LIMIT = 400000;

  typedef struct {
    smd_pkg::kind_t kind;
    logic [7:0]     data;
    logic [23:0]    addr;
    logic [12:0]    len;
    logic           fin;
  } frame_result_t;

  class deframe_checker;
    smd_pkg::phase_t ph;
    logic [4:0]      pos;
    bit              saw_f;
    logic [23:0]     sender;
    logic [7:0]      len_hi;
    logic [12:0]     len;
    logic [12:0]     count;
    logic [1:0]      trailer_left;
    frame_result_t   expected_results[$];
    int unsigned     mismatches;
    int unsigned     results_seen;
    int unsigned     kind_seen[4];

    function new();
      restart_hunt();
      sender = '0;
      len_hi = '0;
      len = '0;
      count = '0;
      trailer_left = '0;
      mismatches = 0;
      results_seen = 0;
      foreach (kind_seen[i]) kind_seen[i] = 0;
    endfunction

    function void restart_hunt();
      ph = smd_pkg::PH_HUNT;
      pos = '0;
      saw_f = 1'b0;
    endfunction

    function void predict(smd_pkg::kind_t k, logic [7:0] d, logic [23:0] a,
                          logic [12:0] l, logic fin);
      frame_result_t r;
      r.kind = k;
      r.data = d;
      r.addr = a;
      r.len = l;
      r.fin = fin;
      expected_results.push_back(r);
    endfunction

    function void take_byte(logic [7:0] b);
      logic [15:0] bits;
      case (ph)
        smd_pkg::PH_HUNT: begin
          if (b == smd_pkg::CH_START) begin
            ph = smd_pkg::PH_HEAD;
            pos = smd_pkg::POS_FIRST;
            saw_f = 1'b0;
          end
        end
        smd_pkg::PH_HEAD: begin
          if (pos == smd_pkg::POS_FIRST) begin
            if (b == smd_pkg::CH_F) begin
              saw_f = 1'b1;
              pos = smd_pkg::POS_SECOND;
            end else if (b != smd_pkg::CH_T) begin
              restart_hunt();
              predict(smd_pkg::KIND_REJECT, '0, '0, '0, 1'b1);
            end else begin
              pos = smd_pkg::POS_SECOND;
            end
          end else if (pos == smd_pkg::POS_SECOND && saw_f) begin
            restart_hunt();
            predict((b == smd_pkg::CH_K) ? smd_pkg::KIND_ACK : smd_pkg::KIND_REJECT,
                    '0, '0, '0, 1'b1);
          end else if (b != smd_pkg::CH_X) begin
            restart_hunt();
            predict(smd_pkg::KIND_REJECT, '0, '0, '0, 1'b1);
          end else begin
            pos = pos + 5'd1;
            if (pos >= smd_pkg::POS_FIELDS) ph = smd_pkg::PH_FIELDS;
          end
        end
        smd_pkg::PH_FIELDS: begin
          if (pos >= smd_pkg::POS_ADDR_LO && pos <= smd_pkg::POS_ADDR_HI)
            sender = {sender[15:0], b};
          else if (pos == smd_pkg::POS_LEN_HIGH)
            len_hi = b;
          if (pos == smd_pkg::POS_LEN_LOW) begin
            bits = {len_hi, b};
            len = 13'(bits >> 3);
            count = '0;
            pos = smd_pkg::POS_PAYLOAD;
            if (len == '0) begin
              ph = smd_pkg::PH_TRAILER;
              trailer_left = smd_pkg::TRAILER_LEN;
              predict(smd_pkg::KIND_EMPTY, '0, sender, '0, 1'b1);
            end else begin
              ph = smd_pkg::PH_PAYLOAD;
            end
          end else begin
            pos = pos + 5'd1;
          end
        end
        smd_pkg::PH_PAYLOAD: begin
          count = count + 13'd1;
          predict(smd_pkg::KIND_DATA, b, sender, len, count >= len);
          if (count >= len) begin
            ph = smd_pkg::PH_TRAILER;
            trailer_left = smd_pkg::TRAILER_LEN;
          end
        end
        smd_pkg::PH_TRAILER: begin
          trailer_left = trailer_left - 2'd1;
          if (trailer_left == '0) restart_hunt();
        end
        default: restart_hunt();
      endcase
    endfunction

    function void match_result(logic [1:0] k, logic [7:0] d, logic [23:0] a,
                               logic [12:0] l, logic fin);
      frame_result_t e;
      results_seen++;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: kind %0d data %02h addr %06h len %0d last %0b",
                   k, d, a, l, fin);
        return;
      end
      e = expected_results.pop_front();
      kind_seen[e.kind]++;
      if (k !== e.kind || d !== e.data || a !== e.addr || l !== e.len || fin !== e.fin) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("result %0d mismatch: expected kind %0d data %02h addr %06h len %0d last %0b",
                   results_seen, e.kind, e.data, e.addr, e.len, e.fin);
          $display("  got kind %0d data %02h addr %06h len %0d last %0b",
                   k, d, a, l, fin);
        end
      end
    endfunction

    function int unsigned pending();
      return expected_results.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  kind;
  logic [7:0]  data_byte;
  logic [23:0] sender_addr;
  logic [12:0] payload_len;
  logic        last;

  deframe_checker sb;
  int unsigned    accepted = 0;
  int unsigned    cycle_count = 0;
  int unsigned    send_idle_pct = 0;
  int unsigned    stall_pct = 0;
  int unsigned    hold_off = 0;

  satellite_message_deframer_unit i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_byte    (in_byte),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .kind       (kind),
    .data_byte  (data_byte),
    .sender_addr(sender_addr),
    .payload_len(payload_len),
    .last       (last)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               sb.pending());
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready)
        sb.match_result(kind, data_byte, sender_addr, payload_len, last);
      if (in_valid && in_ready) begin
        sb.take_byte(in_byte);
        accepted++;
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (hold_off > 0) begin
        out_ready <= 1'b0;
        repeat (hold_off) @(posedge clk);
        hold_off = 0;
      end
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  function automatic logic [7:0] filler(bit all_start);
    return all_start ? smd_pkg::CH_START : 8'($urandom_range(255));
  endfunction

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte <= b;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_ack_frame();
    send_byte(smd_pkg::CH_START);
    send_byte(smd_pkg::CH_F);
    send_byte(smd_pkg::CH_K);
  endtask

  // Break the header at position cut (1..4) with a byte other than the expected one.
  task automatic send_bad_header(input int cut);
    logic [7:0] want;
    logic [7:0] b;
    send_byte(smd_pkg::CH_START);
    for (int p = 1; p < cut; p++) send_byte((p == 1) ? smd_pkg::CH_T : smd_pkg::CH_X);
    want = (cut == 1) ? smd_pkg::CH_T : smd_pkg::CH_X;
    do b = 8'($urandom_range(255)); while (b == want);
    send_byte(b);
  endtask

  task automatic send_msg(input logic [23:0] addr, input logic [15:0] len_bits,
                          input bit all_start);
    send_byte(smd_pkg::CH_START);
    send_byte(smd_pkg::CH_T);
    repeat (3) send_byte(smd_pkg::CH_X);
    repeat (6) send_byte(filler(all_start));
    send_byte(addr[23:16]);
    send_byte(addr[15:8]);
    send_byte(addr[7:0]);
    repeat (2) send_byte(filler(all_start));
    send_byte(len_bits[15:8]);
    send_byte(len_bits[7:0]);
    repeat (int'(len_bits >> 3)) send_byte(filler(all_start));
    repeat (2) send_byte(filler(all_start));
  endtask

  task automatic random_traffic(input int unsigned n_items);
    int unsigned target;
    int unsigned pick;
    logic [15:0] len_bits;
    target = accepted + n_items;
    while (accepted < target) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        len_bits = ($urandom_range(9) == 0) ? 16'($urandom_range(511))
                                            : 16'($urandom_range(103));
        send_msg(24'($urandom), len_bits, 1'b0);
      end else if (pick < 65) begin
        send_ack_frame();
      end else if (pick < 85) begin
        send_bad_header($urandom_range(1, 4));
      end else if (pick < 95) begin
        repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(255)));
      end else begin
        send_byte(smd_pkg::CH_START);
        send_byte(smd_pkg::CH_F);
        send_byte(8'($urandom_range(255)));
      end
    end
  endtask

  // Hold the sender until every predicted result has been checked.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic run_phase(input int unsigned idle_pct, input int unsigned stall,
                           input int unsigned n_items);
    send_idle_pct = idle_pct;
    stall_pct = stall;
    random_traffic(n_items);
    drain();
  endtask

  initial begin
    sb = new();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(smd_pkg::CH_T);
    send_ack_frame();
    send_byte(smd_pkg::CH_START);
    send_byte(smd_pkg::CH_F);
    send_byte(smd_pkg::CH_X);
    for (int c = 1; c <= 4; c++) send_bad_header(c);
    send_msg(24'h000000, 16'h0000, 1'b0);
    send_msg(24'hFFFFFF, 16'h0007, 1'b0);
    send_msg(24'hA5C3F0, 16'h0008, 1'b0);
    send_msg(24'h123456, 16'h000F, 1'b0);
    send_msg(24'h5A3C0F, 16'h0018, 1'b1);
    send_msg(24'($urandom), 16'h0807, 1'b0);
    drain();

    run_phase(0, 0, 170);
    run_phase(74, 0, 170);
    run_phase(0, 74, 170);
    run_phase(19, 19, 170);

    send_idle_pct = 0;
    stall_pct = 0;
    hold_off = 300;
    random_traffic(100);
    drain();

    $display("covered %0d input bytes and %0d results: %0d payload, %0d ack, %0d reject, %0d empty",
             accepted, sb.results_seen, sb.kind_seen[smd_pkg::KIND_DATA],
             sb.kind_seen[smd_pkg::KIND_ACK], sb.kind_seen[smd_pkg::KIND_REJECT],
             sb.kind_seen[smd_pkg::KIND_EMPTY]);
    $display("phases: directed, free flow, sender gaps, receiver stalls, mixed, long hold: %0d bad",
             sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
